[hdl/fsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsm_pkg
// Shared types and constants for the first substring match block.
// ----------------------------------------------------------------------------
package fsm_pkg;

    localparam int CHAR_W = 8;
    localparam int POS_W  = 16;

    typedef enum logic
    {
        FUNC_PATTERN = 1'b0,
        FUNC_TEXT    = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t             func;
        logic [CHAR_W-1:0] char_in;
        logic              last;
    } in_item_t;

    typedef struct packed
    {
        logic             found;
        logic [POS_W-1:0] position;
        logic             pattern_too_long;
    } out_item_t;

    // one staged byte that is moving into the state registers
    typedef struct packed
    {
        logic     step;
        in_item_t item;
    } step_t;

endpackage

[hdl/fsm_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsm_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface fsm_stream_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source
    (
        output valid,
        output data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  data,
        output ready
    );

endinterface

[hdl/fsm_pattern.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsm_pattern
// Pattern store kept newest-first, with length, overflow and closed flags.
// ----------------------------------------------------------------------------
module fsm_pattern
    import fsm_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  step_t                              stage,
    output logic [PATTERN_MAX-1:0][CHAR_W-1:0] pattern_rev,
    output logic [LEN_W-1:0]                   pattern_len,
    output logic                               overflow,
    output logic                               new_pattern
);

    logic [PATTERN_MAX-1:0][CHAR_W-1:0] store_reg;
    logic [PATTERN_MAX-1:0][CHAR_W-1:0] store_next;
    logic [LEN_W-1:0]                   len_reg;
    logic [LEN_W-1:0]                   len_next;
    logic                               ovf_reg;
    logic                               ovf_next;
    logic                               closed_reg;
    logic                               closed_next;
    logic [LEN_W-1:0]                   len_base;
    logic                               ovf_base;
    logic                               pattern_step;

    assign pattern_step = stage.step && (stage.item.func == FUNC_PATTERN);
    assign new_pattern  = pattern_step && closed_reg;
    assign len_base     = closed_reg ? '0 : len_reg;
    assign ovf_base     = closed_reg ? 1'b0 : ovf_reg;

    always_comb
    begin
        store_next  = store_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        closed_next = closed_reg;
        if (pattern_step)
        begin
            len_next    = len_base;
            ovf_next    = ovf_base;
            closed_next = stage.item.last;
            if (len_base < LEN_W'(PATTERN_MAX))
            begin
                // newest byte at tap 0, so tap j holds pattern byte len-1-j
                for (int k = PATTERN_MAX - 1; k > 0; k--)
                begin
                    store_next[k] = store_reg[k-1];
                end
                store_next[0] = stage.item.char_in;
                len_next      = len_base + LEN_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        else if (stage.step)
        begin
            closed_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            closed_reg <= 1'b1;
        end
        else
        begin
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            closed_reg <= closed_next;
        end
    end

    assign pattern_rev = store_reg;
    assign pattern_len = len_reg;
    assign overflow    = ovf_reg;

endmodule

[hdl/fsm_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsm_scan
// Text window, parallel window compare and first-match bookkeeping.
// ----------------------------------------------------------------------------
module fsm_scan
    import fsm_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    parameter int TEXT_MAX    = 65536,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  step_t                              stage,
    input  logic [PATTERN_MAX-1:0][CHAR_W-1:0] pattern_rev,
    input  logic [LEN_W-1:0]                   pattern_len,
    input  logic                               overflow,
    input  logic                               new_pattern,
    output logic                               res_fire,
    output out_item_t                          res
);

    localparam int CNT_W = $clog2(TEXT_MAX + 1);
    localparam int DIF_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [PATTERN_MAX-1:0][CHAR_W-1:0] window_reg;
    logic [PATTERN_MAX-1:0][CHAR_W-1:0] window_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               seen_reg;
    logic                               seen_next;
    logic [POS_W-1:0]                   start_reg;
    logic [POS_W-1:0]                   start_next;
    logic [CNT_W-1:0]                   count_inc;
    logic [DIF_W-1:0]                   start_diff;
    logic                               text_step;
    logic                               scanning;
    logic                               window_eq;
    logic                               hit;

    assign text_step = stage.step && (stage.item.func == FUNC_TEXT);
    assign scanning  = text_step && (count_reg < CNT_W'(TEXT_MAX));
    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        window_next = window_reg;
        for (int k = PATTERN_MAX - 1; k > 0; k--)
        begin
            window_next[k] = window_reg[k-1];
        end
        window_next[0] = stage.item.char_in;
    end

    // compare of the shifted window against the reversed pattern
    always_comb
    begin
        window_eq = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if ((LEN_W'(j) < pattern_len) && (window_next[j] != pattern_rev[j]))
            begin
                window_eq = 1'b0;
            end
        end
    end

    assign start_diff = DIF_W'(count_inc) - DIF_W'(pattern_len);

    always_comb
    begin
        count_next = count_reg;
        seen_next  = seen_reg;
        start_next = start_reg;
        if (new_pattern)
        begin
            count_next = '0;
            seen_next  = 1'b0;
            start_next = '0;
        end
        else if (scanning)
        begin
            count_next = count_inc;
            if (!seen_reg && !overflow && (pattern_len != '0) &&
                (DIF_W'(count_inc) >= DIF_W'(pattern_len)) && window_eq)
            begin
                seen_next  = 1'b1;
                start_next = POS_W'(start_diff);
            end
        end
    end

    assign res_fire             = text_step && stage.item.last;
    assign hit                  = seen_next && !overflow && (pattern_len != '0);
    assign res.found            = hit;
    assign res.position         = hit ? start_next : '0;
    assign res.pattern_too_long = overflow;

    always_ff @(posedge clk)
    begin
        if (scanning)
        begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
        end
        else if (res_fire)
        begin
            count_reg <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            seen_reg  <= seen_next;
            start_reg <= start_next;
        end
    end

endmodule

[hdl/first_substring_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_substring_match
// Streaming search for the first occurrence of a pattern in a byte text.
//
// item channel: one byte per transaction. func selects pattern or text,
// last closes the pattern or ends the text. A pattern byte after a closed
// pattern starts a new pattern; the pattern is kept across texts.
// result channel: one transaction per text byte with last set, carrying
// found, the zero-based start position and the pattern_too_long flag.
// Flow: a byte is registered in the input register at its transaction and
// moves on into the state and result registers when it advances, which a
// waiting result can hold off; the result of a final text byte is registered.
// Throughput: one byte per cycle while no result waits on the receiver; the
// text window is compared against all PATTERN_MAX pattern taps combinationally.
// Reset: pattern empty and closed, scan state cleared, both channels idle.
// Stall: while a result waits on the receiver, one more byte is held in the
// input register and further bytes wait; nothing is dropped.
// ----------------------------------------------------------------------------
module first_substring_match
    import fsm_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    parameter int TEXT_MAX    = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    fsm_stream_if.sink        item,
    fsm_stream_if.source      result
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    in_item_t                           item_reg;
    logic                               item_valid_reg;
    logic                               item_valid_next;
    out_item_t                          result_reg;
    logic                               result_valid_reg;
    logic                               result_valid_next;
    logic                               advance;
    step_t                              stage;
    logic [PATTERN_MAX-1:0][CHAR_W-1:0] pattern_rev;
    logic [LEN_W-1:0]                   pattern_len;
    logic                               overflow;
    logic                               new_pattern;
    logic                               res_fire;
    out_item_t                          res;

    assign advance    = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign stage.step = advance;
    assign stage.item = item_reg;

    fsm_pattern #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_pattern (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .pattern_rev (pattern_rev),
        .pattern_len (pattern_len),
        .overflow    (overflow),
        .new_pattern (new_pattern)
    );

    fsm_scan #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX),
        .LEN_W       (LEN_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .pattern_rev (pattern_rev),
        .pattern_len (pattern_len),
        .overflow    (overflow),
        .new_pattern (new_pattern),
        .res_fire    (res_fire),
        .res         (res)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item.ready)
        begin
            item_valid_next = item.valid;
        end
        result_valid_next = result_valid_reg;
        if (advance && res_fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= item.data;
        end
        if (advance && res_fire)
        begin
            result_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

    a_found_excl_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.data.found && result.data.pattern_too_long))
        else $error("found and pattern_too_long both set");

    a_position_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.data.found) |-> (result.data.position == '0))
        else $error("position nonzero without a match");

    a_ready_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid_reg |-> item.ready)
        else $error("input stalled with an empty result register");

    a_result_from_last_text : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |->
            ($past(item_reg.func) == FUNC_TEXT) && $past(item_reg.last))
        else $error("result not caused by a final text byte");

endmodule

[bench/first_substring_match_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_substring_match_test
// Self-checking bench for the streaming first substring search. A queue of
// pattern and text bytes feeds a valid/ready driver; every accepted byte goes
// through a behavioral search model that predicts the found flag, start
// position and overflow flag of each finished text. A monitor on the result
// channel compares each result with the oldest prediction. Directed cases
// come first, then random pattern/text sequences with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module first_substring_match_test;

    import fsm_pkg::*;

    localparam int PAT_DEPTH   = 16;
    localparam int TEXT_LIMIT  = 65536;
    localparam int RANDOM_BYTES = 1650;
    localparam int CYCLE_LIMIT = 100000;
    localparam int IDLE_PCT    = 33;

    logic clk;
    logic rst_n;

    fsm_stream_if #(.T(in_item_t))  item_if ();
    fsm_stream_if #(.T(out_item_t)) result_if ();

    first_substring_match #(
        .PATTERN_MAX (PAT_DEPTH),
        .TEXT_MAX    (TEXT_LIMIT)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    in_item_t    pending_bytes[$];
    out_item_t   expected_results[$];
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned random_count = 0;
    bit          steady;

    // search model state
    logic [CHAR_W-1:0] pat_mem[PAT_DEPTH];
    logic [CHAR_W-1:0] window[PAT_DEPTH];
    int unsigned       pat_len = 0;
    bit                pat_closed = 1'b1;
    bit                pat_overflow = 1'b0;
    int unsigned       text_seen = 0;
    bit                hit_seen = 1'b0;
    int unsigned       hit_start = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    assign steady = (cycle_count >= 1200) && (cycle_count < 1700);

    task automatic clear_scan();
        for (int i = 0; i < PAT_DEPTH; i++)
            window[i] = '0;
        text_seen = 0;
        hit_seen  = 1'b0;
        hit_start = 0;
    endtask

    task automatic predict_search(in_item_t it);
        out_item_t res;
        bit        same;
        if (it.func == FUNC_PATTERN)
        begin
            if (pat_closed)
            begin
                pat_len      = 0;
                pat_overflow = 1'b0;
                pat_closed   = 1'b0;
                clear_scan();
            end
            if (pat_len < PAT_DEPTH)
            begin
                pat_mem[pat_len] = it.char_in;
                pat_len++;
            end
            else
                pat_overflow = 1'b1;
            if (it.last)
                pat_closed = 1'b1;
        end
        else
        begin
            pat_closed = 1'b1;
            if (text_seen < TEXT_LIMIT)
            begin
                for (int k = PAT_DEPTH - 1; k > 0; k--)
                    window[k] = window[k-1];
                window[0] = it.char_in;
                text_seen++;
                if (!hit_seen && !pat_overflow && pat_len > 0 && text_seen >= pat_len)
                begin
                    same = 1'b1;
                    for (int j = 0; j < pat_len; j++)
                        if (window[j] != pat_mem[pat_len-1-j])
                            same = 1'b0;
                    if (same)
                    begin
                        hit_seen  = 1'b1;
                        hit_start = text_seen - pat_len;
                    end
                end
            end
            if (it.last)
            begin
                res.found            = hit_seen && !pat_overflow && pat_len > 0;
                res.position         = res.found ? hit_start[POS_W-1:0] : '0;
                res.pattern_too_long = pat_overflow;
                expected_results.push_back(res);
                clear_scan();
            end
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_if.valid <= 1'b0;
            item_if.data  <= '0;
        end
        else
        begin
            if (item_if.valid && item_if.ready)
                predict_search(item_if.data);
            if (!item_if.valid || item_if.ready)
            begin
                if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    item_if.data  <= pending_bytes.pop_front();
                    item_if.valid <= 1'b1;
                end
                else
                    item_if.valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
            result_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = result_if.data;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction: found %0d position %0d too_long %0d",
                       got.found, got.position, got.pattern_too_long);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, got.found);
                    error_count++;
                end
                if (got.position !== want.position)
                begin
                    $error("position: expected %0d, actual %0d", want.position, got.position);
                    error_count++;
                end
                if (got.pattern_too_long !== want.pattern_too_long)
                begin
                    $error("pattern_too_long: expected %0d, actual %0d",
                           want.pattern_too_long, got.pattern_too_long);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("first_substring_match: mismatch");
            $finish;
        end
    end

    task automatic add_byte(func_t f, logic [CHAR_W-1:0] c, bit l);
        in_item_t it;
        it.func    = f;
        it.char_in = c;
        it.last    = l;
        pending_bytes.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || item_if.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [CHAR_W-1:0] cur_pat[$];
        logic [CHAR_W-1:0] base;
        logic [CHAR_W-1:0] b;
        int                plen;
        int                tlen;
        int                plant;
        int                pick;

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty pattern right after reset
        add_byte(FUNC_TEXT, 8'h00, 1'b1);
        // extreme bytes, match at start, later match ignored
        add_byte(FUNC_PATTERN, 8'h00, 1'b0);
        add_byte(FUNC_PATTERN, 8'hFF, 1'b1);
        add_byte(FUNC_TEXT, 8'h00, 1'b0);
        add_byte(FUNC_TEXT, 8'hFF, 1'b0);
        add_byte(FUNC_TEXT, 8'h00, 1'b0);
        add_byte(FUNC_TEXT, 8'hFF, 1'b1);
        // text closes an open pattern
        add_byte(FUNC_PATTERN, 8'h41, 1'b0);
        add_byte(FUNC_TEXT, 8'h41, 1'b1);
        // pattern over the store
        for (int i = 0; i < PAT_DEPTH + 1; i++)
            add_byte(FUNC_PATTERN, 8'h5A, i == PAT_DEPTH);
        add_byte(FUNC_TEXT, 8'h5A, 1'b1);
        wait_drained();

        while (random_count < RANDOM_BYTES)
        begin
            pick = int'($urandom_range(99));
            base = CHAR_W'($urandom_range(255));
            if (pick < 8)
            begin
                add_byte(func_t'($urandom_range(1)), CHAR_W'($urandom_range(255)),
                         $urandom_range(3) == 0);
                random_count++;
            end
            else
            begin
                if (pick < 20)
                    plen = int'($urandom_range(PAT_DEPTH + 1, PAT_DEPTH + 4));
                else if ($urandom_range(3) == 0)
                    plen = int'($urandom_range(1, PAT_DEPTH));
                else
                    plen = int'($urandom_range(1, 5));
                if (pick < 20 || $urandom_range(9) < 7)
                begin
                    cur_pat.delete();
                    for (int i = 0; i < plen; i++)
                    begin
                        b = base ^ CHAR_W'($urandom_range(1));
                        if (i < PAT_DEPTH)
                            cur_pat.push_back(b);
                        // open pattern: leave the final byte unmarked
                        add_byte(FUNC_PATTERN, b, (i == plen - 1) && (pick >= 14));
                        random_count++;
                    end
                end
                tlen  = int'($urandom_range(1, 40));
                plant = ($urandom_range(1) == 0) ? int'($urandom_range(0, tlen)) : -1000;
                for (int i = 0; i < tlen; i++)
                begin
                    if ($urandom_range(9) == 0)
                        b = CHAR_W'($urandom_range(255));
                    else
                        b = base ^ CHAR_W'($urandom_range(1));
                    if (i >= plant && i - plant < cur_pat.size())
                        b = cur_pat[i - plant];
                    add_byte(FUNC_TEXT, b, i == tlen - 1);
                    random_count++;
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("first_substring_match: match");
        else
            $display("first_substring_match: mismatch");
        $finish;
    end

endmodule

[sim.f]
hdl/fsm_pkg.sv
hdl/fsm_stream_if.sv
hdl/fsm_pattern.sv
hdl/fsm_scan.sv
hdl/first_substring_match.sv
bench/first_substring_match_test.sv
